FILE: src/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int SUM_W  = ADDR_W + 1;

    // Field widths of the request and result beats
    localparam int IDX_W  = 11;
    localparam int BYTE_W = 8;
    localparam int CELL_W = 2 * BYTE_W;

    localparam logic [BYTE_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [BYTE_W-1:0] RESET_ATTR   = 8'h07;

    typedef enum logic [1:0] {
        REQ_PUT       = 2'd0,
        REQ_BACKSPACE = 2'd1,
        REQ_CLEAR     = 2'd2,
        REQ_READ      = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t          req_type;
        logic [BYTE_W-1:0]  char_code;
        logic [IDX_W-1:0]   cell_index;
    } req_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   cursor_cell;
        logic               scrolled;
        logic [BYTE_W-1:0]  read_char;
        logic [BYTE_W-1:0]  read_attr;
    } rsp_item_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic sweep_start;
        logic sweep_step;
        logic sweep_scroll;
        logic sweep_rst_attr;
        logic load_out;
    } tcw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        req_type_t req_type;
        logic      wraps;
        logic      sweep_done;
        logic      out_free;
    } tcw_sts_t;

endpackage

FILE: src/tcw_ram.sv
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/tcw_ctrl.sv
`timescale 1ns / 1ps

module tcw_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tcw_pkg::tcw_sts_t sts,
    output tcw_pkg::tcw_cmd_t cmd
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_SCROLL,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_step     = 1'b1;
                cmd.sweep_rst_attr = 1'b1;
                if (sts.sweep_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec        = 1'b1;
                cmd.sweep_start = 1'b1;
                unique case (sts.req_type) inside
                    REQ_CLEAR: state_next = ST_CLEAR;
                    REQ_READ:  state_next = ST_FINISH;
                    REQ_PUT, REQ_BACKSPACE:
                    begin
                        if (sts.wraps)
                        begin
                            state_next = ST_SCROLL;
                        end
                        else if (sts.out_free)
                        begin
                            cmd.load_out = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    default: state_next = ST_FINISH;
                endcase
            end
            ST_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCROLL:
            begin
                cmd.sweep_step   = 1'b1;
                cmd.sweep_scroll = 1'b1;
                if (sts.sweep_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    // a request is only taken once the power-on blanking sweep is over
    a_no_accept_during_init: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT) |-> !in_ready)
        else $error("request taken during initial blanking");
`endif

endmodule

FILE: src/tcw_datapath.sv
`timescale 1ns / 1ps

module tcw_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tcw_pkg::req_item_t        in_data,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [tcw_pkg::BYTE_W-1:0] cfg_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output tcw_pkg::rsp_item_t        out_data,
    input  tcw_pkg::tcw_cmd_t         cmd,
    output tcw_pkg::tcw_sts_t         sts
);
    import tcw_pkg::*;

    req_item_t          req_reg;
    logic [ADDR_W-1:0]  cursor_reg,  cursor_next;
    logic [COL_W-1:0]   col_reg,     col_next;
    logic [CNT_W-1:0]   sweep_reg,   sweep_next;
    logic [BYTE_W-1:0]  attr_reg;
    logic               scrolled_reg, scrolled_next;
    logic               out_valid_reg, out_valid_next;
    rsp_item_t          out_reg,     out_next;

    logic               wr_en, rd_en;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [CELL_W-1:0]  wr_data, rd_data;

    logic               is_nl, in_range, wraps, out_free, sweep_done;
    logic [SUM_W-1:0]   cur_plus, cur_nl, put_sum;
    logic [ADDR_W-1:0]  cur_dec;
    logic [CNT_W-1:0]   sweep_dec, sweep_fwd;
    logic [BYTE_W-1:0]  blank_attr;
    logic [CELL_W-1:0]  blank_cell;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign is_nl      = (req_reg.char_code == NEWLINE_CHAR);
    assign in_range   = (req_reg.cell_index < IDX_W'(CELLS));
    assign cur_plus   = {1'b0, cursor_reg} + SUM_W'(1);
    assign cur_nl     = {1'b0, cursor_reg} + SUM_W'(COLUMNS) - SUM_W'(col_reg);
    assign put_sum    = is_nl ? cur_nl : cur_plus;
    assign wraps      = (req_reg.req_type == REQ_PUT) && (put_sum >= SUM_W'(CELLS));
    assign cur_dec    = cursor_reg - ADDR_W'(1);
    assign sweep_dec  = sweep_reg - CNT_W'(1);
    assign sweep_fwd  = sweep_reg + CNT_W'(COLUMNS);
    assign sweep_done = (sweep_reg == CNT_W'(CELLS));
    assign out_free   = !out_valid_reg || out_ready;
    assign blank_attr = cmd.sweep_rst_attr ? RESET_ATTR : attr_reg;
    assign blank_cell = {blank_attr, BLANK_CHAR};

    always_comb
    begin
        cursor_next    = cursor_reg;
        col_next       = col_reg;
        sweep_next     = sweep_reg;
        scrolled_next  = scrolled_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        wr_en          = 1'b0;
        wr_addr        = cursor_reg;
        wr_data        = {attr_reg, req_reg.char_code};
        rd_en          = 1'b0;
        rd_addr        = req_reg.cell_index[ADDR_W-1:0];

        if (cmd.accept)
        begin
            scrolled_next = 1'b0;
        end

        if (cmd.exec)
        begin
            case (req_reg.req_type)
                REQ_PUT:
                begin
                    wr_en = !is_nl;
                    if (wraps)
                    begin
                        cursor_next   = ADDR_W'(CELLS - COLUMNS);
                        col_next      = '0;
                        scrolled_next = 1'b1;
                    end
                    else
                    begin
                        cursor_next = put_sum[ADDR_W-1:0];
                        if (is_nl || col_reg == COL_W'(COLUMNS - 1))
                        begin
                            col_next = '0;
                        end
                        else
                        begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                end
                REQ_BACKSPACE:
                begin
                    if (cursor_reg != '0)
                    begin
                        cursor_next = cur_dec;
                        col_next    = (col_reg == '0) ? COL_W'(COLUMNS - 1)
                                                      : col_reg - COL_W'(1);
                        wr_en       = 1'b1;
                        wr_addr     = cur_dec;
                        wr_data     = blank_cell;
                    end
                end
                REQ_CLEAR:
                begin
                    cursor_next = '0;
                    col_next    = '0;
                end
                default:
                begin
                    rd_en = in_range;
                end
            endcase
        end

        if (cmd.sweep_start)
        begin
            sweep_next = '0;
        end

        // Step n writes cell n-1; in a scroll it also fetches the cell one row below n
        if (cmd.sweep_step)
        begin
            if (!sweep_done)
            begin
                sweep_next = sweep_reg + CNT_W'(1);
            end
            if (sweep_reg != '0)
            begin
                wr_en   = 1'b1;
                wr_addr = sweep_dec[ADDR_W-1:0];
                if (cmd.sweep_scroll && sweep_reg <= CNT_W'(CELLS - COLUMNS))
                begin
                    wr_data = rd_data;
                end
                else
                begin
                    wr_data = blank_cell;
                end
            end
            if (cmd.sweep_scroll && sweep_reg < CNT_W'(CELLS - COLUMNS))
            begin
                rd_en   = 1'b1;
                rd_addr = sweep_fwd[ADDR_W-1:0];
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next       = 1'b1;
            out_next.cursor_cell = IDX_W'(cursor_next);
            out_next.scrolled    = scrolled_reg;
            if (req_reg.req_type == REQ_READ && in_range)
            begin
                out_next.read_char = rd_data[BYTE_W-1:0];
                out_next.read_attr = rd_data[CELL_W-1:BYTE_W];
            end
            else
            begin
                out_next.read_char = '0;
                out_next.read_attr = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            col_reg       <= '0;
            sweep_reg     <= '0;
            attr_reg      <= RESET_ATTR;
            scrolled_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            sweep_reg     <= sweep_next;
            scrolled_reg  <= scrolled_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= in_data;
        end
        out_reg <= out_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_data       = out_reg;
    assign sts.req_type   = req_reg.req_type;
    assign sts.wraps      = wraps;
    assign sts.sweep_done = sweep_done;
    assign sts.out_free   = out_free;

`ifndef ASSERT_OFF
    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg < ADDR_W'(CELLS))
        else $error("cursor beyond last cell");
    a_column_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < COL_W'(COLUMNS))
        else $error("column counter beyond row width");
`endif

endmodule

FILE: src/text_console_writer.sv
`timescale 1ns / 1ps

// Text console writer: an 80 x 25 character screen store with a cursor.
// in channel (in_valid / in_ready / in_data): one request beat, put character
//   (newline moves to the next row), backspace, clear screen or read cell.
// out channel (out_valid / out_ready / out_data): exactly one result beat per
//   request, carrying the cursor after the request, the scroll flag and, for
//   a read, the cell's character and attribute bytes (zero otherwise).
// cfg channel (cfg_valid / cfg_ready / cfg_data): the attribute byte stored
//   with every written cell and every cell blanked by a request; always ready,
//   write only while idle.
// A put that does not scroll, or a backspace, loads its result in the EXEC
//   state when the output register is free; a read (registered screen RAM
//   read), a stalled result and a finished clear or scroll are loaded from
//   the FINISH state. The scroll and clear walk the screen RAM one cell per
//   cycle, copying row by row and blanking. One request is in work at a time;
//   the next is taken the cycle after the previous result is loaded.
// Reset: the screen is blanked (space, attribute 0x07) by a pass during
//   which in_ready stays low; cfg writes are still taken.
// A stalled receiver holds the result in the output register; one further
//   request may be taken, but its result waits until that beat is taken.
module text_console_writer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  tcw_pkg::req_item_t         in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output tcw_pkg::rsp_item_t         out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [tcw_pkg::BYTE_W-1:0] cfg_data
);
    import tcw_pkg::*;

    tcw_cmd_t cmd;
    tcw_sts_t sts;

    // attribute register takes a write on any cycle
    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcw_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

`ifndef ASSERT_OFF
    // one request in work at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken while one is in work");
    // a scroll always leaves the cursor at the start of the bottom row
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.scrolled) |->
            (out_data.cursor_cell == IDX_W'(CELLS - COLUMNS)))
        else $error("scrolled result with cursor off the bottom row start");
`endif

endmodule
